// ----- hw/rtl/assert_macros.svh -----
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while reset is high
`define TCC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcc assertion failed");

// next-cycle implication, ignored while reset is high
`define TCC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcc assertion failed");

// next-cycle implication, also checked across reset
`define TCC_ASSERT_NXT_ALL(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("tcc assertion failed");

`endif

// ----- hw/rtl/tcc_pkg.sv -----
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types, codes and the color palette of the text color code stack.
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

   localparam int CODE_W     = 7;
   localparam int ENTRY_W    = 8;
   localparam int LEVEL_W    = 7;
   localparam int COLOR_W    = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 8;
   localparam int PROD_W     = 15;

   localparam logic [CODE_W-1:0]  CODE_SAVE    = 7'h73;  // 's'
   localparam logic [CODE_W-1:0]  CODE_RESTORE = 7'h72;  // 'r'
   localparam logic [CODE_W-1:0]  CODE_BLINK   = 7'h62;  // 'b'
   localparam logic [ENTRY_W-1:0] CODE_DEFAULT = 8'h63;  // 'c'

   localparam logic [LEVEL_W-1:0] FULL_BRIGHT  = 7'd100;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_USER_RED     = 3'd0,
      REG_USER_GREEN   = 3'd1,
      REG_USER_BLUE    = 3'd2,
      REG_BASE_ALPHA   = 3'd3,
      REG_BLINK_ENABLE = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [COLOR_W-1:0] user_red;
      logic [COLOR_W-1:0] user_green;
      logic [COLOR_W-1:0] user_blue;
      logic [COLOR_W-1:0] base_alpha;
      logic               blink_enable;
   } cfg_type;

   typedef struct packed {
      logic               push;
      logic               pop;
      logic               set;
      logic               negate;
      logic [ENTRY_W-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic               hit;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } palette_type;

   function automatic palette_type palette_lookup(input logic [ENTRY_W-1:0] mag);
      palette_type p;
      logic [3*COLOR_W-1:0] rgb;
      p   = '0;
      rgb = '0;
      p.hit = 1'b1;
      case (mag)
         8'h30: rgb = 24'h02FF80;
         8'h31: rgb = 24'h60A0FF;
         8'h32: rgb = 24'hFFC040;
         8'h33: rgb = 24'hFF4040;
         8'h34: rgb = 24'h808080;
         8'h35: rgb = 24'hFFFFFF;
         8'h36: rgb = 24'h603000;
         8'h37: rgb = 24'h993333;
         8'h38: rgb = 24'hC040C0;
         8'h39: rgb = 24'hFF6600;
         8'h41: rgb = 24'hFFB7B7;
         8'h42: rgb = 24'hCC3333;
         8'h43: rgb = 24'h663333;
         8'h44: rgb = 24'hF8984E;
         8'h45: rgb = 24'hFFFFB7;
         8'h46: rgb = 24'hCCCC33;
         8'h47: rgb = 24'h666633;
         8'h48: rgb = 24'hCCFC58;
         8'h49: rgb = 24'hB7FFB7;
         8'h4A: rgb = 24'h33CC33;
         8'h4B: rgb = 24'h336633;
         8'h4C: rgb = 24'h3FFF98;
         8'h4D: rgb = 24'hB7FFFF;
         8'h4E: rgb = 24'h33CCCC;
         8'h4F: rgb = 24'h336666;
         8'h50: rgb = 24'h4FCCF8;
         8'h51: rgb = 24'hB7B7FF;
         8'h52: rgb = 24'h3333CC;
         8'h53: rgb = 24'h333366;
         8'h54: rgb = 24'hA049FF;
         8'h55: rgb = 24'hFFB7FF;
         8'h56: rgb = 24'hCC33CC;
         8'h57: rgb = 24'h663366;
         8'h58: rgb = 24'hFF01D5;
         8'h59: rgb = 24'hC7D1E2;
         8'h5A: rgb = 24'h323232;
         8'h75: rgb = 24'h78F078;
         8'h76: rgb = 24'h7878F0;
         8'h77: rgb = 24'hE6E66E;
         8'h78: rgb = 24'hFA6464;
         default: p.hit = 1'b0;
      endcase
      p.red   = rgb[23:16];
      p.green = rgb[15:8];
      p.blue  = rgb[7:0];
      return p;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tcc_ifs.sv -----
// ----------------------------------------------------------------------------
// tcc_ifs
// Valid/ready channels of the text color code stack: codes, colors, csr writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcc_req_if;
   logic                         valid;
   logic                         ready;
   logic [tcc_pkg::CODE_W-1:0]   code;
   logic [tcc_pkg::LEVEL_W-1:0]  blink_level;

   modport source (output valid, code, blink_level, input ready);
   modport sink   (input valid, code, blink_level, output ready);
endinterface

interface tcc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tcc_pkg::COLOR_W-1:0]  red;
   logic [tcc_pkg::COLOR_W-1:0]  green;
   logic [tcc_pkg::COLOR_W-1:0]  blue;
   logic [tcc_pkg::COLOR_W-1:0]  alpha;

   modport source (output valid, red, green, blue, alpha, input ready);
   modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

interface tcc_csr_if;
   logic                           valid;
   logic                           ready;
   logic [tcc_pkg::CSR_ADDR_W-1:0] index;
   logic [tcc_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tcc_cell.sv -----
// ----------------------------------------------------------------------------
// tcc_cell
// One stack slot; shifts toward its neighbors on push and pop, the top slot also takes set and negate.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_cell #(
   parameter bit TOP = 1'b0
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire tcc_pkg::cmd_type             cmd,
   input  wire logic [tcc_pkg::ENTRY_W-1:0]  above,
   input  wire logic [tcc_pkg::ENTRY_W-1:0]  below,
   output logic      [tcc_pkg::ENTRY_W-1:0]  value,
   output logic      [tcc_pkg::ENTRY_W-1:0]  value_next
);
   import tcc_pkg::*;

   logic [ENTRY_W-1:0] value_ff;
   logic [ENTRY_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (TOP) begin
         // the top slot keeps its value on push, the copy goes below
         if (cmd.set) begin
            value_in = cmd.value;
         end else if (cmd.negate) begin
            value_in = 8'(8'd0 - value_ff);
         end else if (cmd.pop) begin
            value_in = below;
         end
      end else begin
         if (cmd.push) begin
            value_in = above;
         end else if (cmd.pop) begin
            value_in = below;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (TOP && reset) begin
         value_ff <= CODE_DEFAULT;
      end else begin
         value_ff <= value_in;
      end
   end

   assign value      = value_ff;
   assign value_next = value_in;

endmodule

`default_nettype wire

// ----- hw/rtl/tcc_stack.sv -----
// ----------------------------------------------------------------------------
// tcc_stack
// Row of stack cells with the current entry in the first cell, plus depth count.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_stack #(
   parameter int STACK_DEPTH = 10
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         accept,
   input  wire logic [tcc_pkg::CODE_W-1:0]   code,
   input  wire logic                         blink_enable,
   output logic      [tcc_pkg::ENTRY_W-1:0]  top_next
);
   import tcc_pkg::*;

   localparam int TOP_W = $clog2(STACK_DEPTH);

   logic [TOP_W-1:0]   top_ff;
   logic [TOP_W-1:0]   top_in;
   cmd_type            cmd;
   logic [ENTRY_W-1:0] cell_q [STACK_DEPTH];
   logic [ENTRY_W-1:0] cell_d [STACK_DEPTH];

   always_comb begin
      cmd        = '0;
      cmd.value  = {1'b0, code};
      cmd.push   = accept && (code == CODE_SAVE) && (top_ff != TOP_W'(STACK_DEPTH - 1));
      cmd.pop    = accept && (code == CODE_RESTORE) && (top_ff != '0);
      cmd.negate = accept && (code == CODE_BLINK) && blink_enable;
      cmd.set    = accept && (code != CODE_SAVE) && (code != CODE_RESTORE)
                   && (code != CODE_BLINK);
   end

   always_comb begin
      top_in = top_ff;
      if (cmd.push) begin
         top_in = top_ff + 1'b1;
      end else if (cmd.pop) begin
         top_in = top_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= '0;
      end else begin
         top_ff <= top_in;
      end
   end

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [ENTRY_W-1:0] above;
      logic [ENTRY_W-1:0] below;

      if (i == 0) begin : g_first
         assign above = cell_q[i];
      end else begin : g_mid
         assign above = cell_q[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_last
         assign below = cell_q[i];
      end else begin : g_inner
         assign below = cell_q[i+1];
      end

      tcc_cell #(
         .TOP (i == 0)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .above      (above),
         .below      (below),
         .value      (cell_q[i]),
         .value_next (cell_d[i])
      );
   end

   assign top_next = cell_d[0];

endmodule

`default_nettype wire

// ----- hw/rtl/tcc_color.sv -----
// ----------------------------------------------------------------------------
// tcc_color
// Palette lookup and alpha scaling of the current entry, two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_color (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire tcc_pkg::cfg_type             cfg,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire logic [tcc_pkg::ENTRY_W-1:0]  entry,
   input  wire logic [tcc_pkg::LEVEL_W-1:0]  level,
   output logic                              out_valid,
   input  wire logic                         out_ready,
   output logic      [tcc_pkg::COLOR_W-1:0]  red,
   output logic      [tcc_pkg::COLOR_W-1:0]  green,
   output logic      [tcc_pkg::COLOR_W-1:0]  blue,
   output logic      [tcc_pkg::COLOR_W-1:0]  alpha
);
   import tcc_pkg::*;

   // floor(x / 100) == (x * 5243) >> 19 for every x below 43690
   localparam logic [12:0] RECIP_100 = 13'd5243;
   localparam int          SCALE_W   = PROD_W + 13;

   logic               out_load;
   logic               mid_take;

   logic [ENTRY_W-1:0] mag;
   palette_type        pal;
   logic [LEVEL_W-1:0] bright;

   logic               mid_valid_ff, mid_valid_in;
   logic [COLOR_W-1:0] mid_red_ff, mid_red_in;
   logic [COLOR_W-1:0] mid_green_ff, mid_green_in;
   logic [COLOR_W-1:0] mid_blue_ff, mid_blue_in;
   logic [PROD_W-1:0]  mid_prod_ff, mid_prod_in;

   logic               out_valid_ff, out_valid_in;
   logic [COLOR_W-1:0] out_red_ff, out_green_ff, out_blue_ff, out_alpha_ff;
   logic [SCALE_W-1:0] scaled;

   assign out_load = !out_valid_ff || out_ready;
   assign mid_take = !mid_valid_ff || out_load;
   assign in_ready = mid_take;

   // stage one: magnitude, palette, brightness, product
   always_comb begin
      mag    = entry[ENTRY_W-1] ? 8'(8'd0 - entry) : entry;
      pal    = palette_lookup(mag);
      if ((entry != '0) && !entry[ENTRY_W-1]) begin
         bright = FULL_BRIGHT;
      end else if (level > FULL_BRIGHT) begin
         bright = FULL_BRIGHT;
      end else begin
         bright = level;
      end
      mid_red_in   = pal.hit ? pal.red   : cfg.user_red;
      mid_green_in = pal.hit ? pal.green : cfg.user_green;
      mid_blue_in  = pal.hit ? pal.blue  : cfg.user_blue;
      mid_prod_in  = PROD_W'(cfg.base_alpha) * PROD_W'(bright);
      mid_valid_in = mid_take ? in_valid : mid_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else begin
         mid_valid_ff <= mid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_take) begin
         mid_red_ff   <= mid_red_in;
         mid_green_ff <= mid_green_in;
         mid_blue_ff  <= mid_blue_in;
         mid_prod_ff  <= mid_prod_in;
      end
   end

   // stage two: divide the product by 100
   assign scaled       = SCALE_W'(mid_prod_ff) * SCALE_W'(RECIP_100);
   assign out_valid_in = out_load ? mid_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_red_ff   <= mid_red_ff;
         out_green_ff <= mid_green_ff;
         out_blue_ff  <= mid_blue_ff;
         out_alpha_ff <= scaled[26:19];
      end
   end

   assign out_valid = out_valid_ff;
   assign red       = out_red_ff;
   assign green     = out_green_ff;
   assign blue      = out_blue_ff;
   assign alpha     = out_alpha_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/text_color_code_stack_core.sv -----
// ----------------------------------------------------------------------------
// text_color_code_stack_core: one code transaction per cycle while the color path does not stall
// every code but save gives one color transaction; save gives none
// the stack cells update in the cycle of the code, the color path is three registers
// synchronous reset: empty pipeline, top slot 'c', depth zero, registers at defaults
// ----------------------------------------------------------------------------
`default_nettype none

module text_color_code_stack_core #(
   parameter int STACK_DEPTH = 10
) (
   input  wire logic  clock,
   input  wire logic  reset,
   tcc_req_if.sink    req_ch,
   tcc_rsp_if.source  rsp_ch,
   tcc_csr_if.sink    csr_ch
);
   import tcc_pkg::*;

   cfg_type            cfg_ff;
   cfg_type            cfg_in;

   logic               req_accept;
   logic               color_ready;
   logic [ENTRY_W-1:0] top_next;

   logic               s1_valid_ff, s1_valid_in;
   logic [ENTRY_W-1:0] s1_entry_ff;
   logic [LEVEL_W-1:0] s1_level_ff;

   // configuration writes
   assign csr_ch.ready = !reset;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            REG_USER_RED:     cfg_in.user_red     = csr_ch.data;
            REG_USER_GREEN:   cfg_in.user_green   = csr_ch.data;
            REG_USER_BLUE:    cfg_in.user_blue    = csr_ch.data;
            REG_BASE_ALPHA:   cfg_in.base_alpha   = csr_ch.data;
            REG_BLINK_ENABLE: cfg_in.blink_enable = csr_ch.data[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.user_red     <= 8'hFF;
         cfg_ff.user_green   <= 8'hFF;
         cfg_ff.user_blue    <= 8'hFF;
         cfg_ff.base_alpha   <= 8'hFF;
         cfg_ff.blink_enable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // code transactions
   assign req_ch.ready = !reset && (!s1_valid_ff || color_ready);
   assign req_accept   = req_ch.valid && req_ch.ready;

   tcc_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .code         (req_ch.code),
      .blink_enable (cfg_ff.blink_enable),
      .top_next     (top_next)
   );

   // save codes update the stack only
   always_comb begin
      s1_valid_in = s1_valid_ff && !color_ready;
      if (req_accept) begin
         s1_valid_in = (req_ch.code != CODE_SAVE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_entry_ff <= top_next;
         s1_level_ff <= req_ch.blink_level;
      end
   end

   tcc_color u_color (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (s1_valid_ff),
      .in_ready  (color_ready),
      .entry     (s1_entry_ff),
      .level     (s1_level_ff),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .red       (rsp_ch.red),
      .green     (rsp_ch.green),
      .blue      (rsp_ch.blue),
      .alpha     (rsp_ch.alpha)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/tcc_checker.sv -----
// ----------------------------------------------------------------------------
// tcc_checker
// Port-level checks of the text color code stack, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tcc_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [tcc_pkg::COLOR_W-1:0]  rsp_red,
   input wire logic [tcc_pkg::COLOR_W-1:0]  rsp_green,
   input wire logic [tcc_pkg::COLOR_W-1:0]  rsp_blue,
   input wire logic [tcc_pkg::COLOR_W-1:0]  rsp_alpha
);
   import tcc_pkg::*;

   logic                 rsp_stall;
   logic                 out_free;
   logic [4*COLOR_W-1:0] rsp_data;

   assign rsp_stall = rsp_valid && !rsp_ready;
   // a free output slot lets the whole pipeline move
   assign out_free  = !rsp_valid || rsp_ready;
   assign rsp_data  = {rsp_red, rsp_green, rsp_blue, rsp_alpha};

   `TCC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid)
   `TCC_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_stall, $stable(rsp_data))
   `TCC_ASSERT_NXT_ALL(a_reset_empty, clock, reset, !rsp_valid)
   `TCC_ASSERT_IMP(a_ready_when_free, clock, reset, out_free, req_ready)

endmodule

bind text_color_code_stack_core tcc_checker u_tcc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_red   (rsp_ch.red),
   .rsp_green (rsp_ch.green),
   .rsp_blue  (rsp_ch.blue),
   .rsp_alpha (rsp_ch.alpha)
);

`default_nettype wire
